/* src/three_spin_heat_bath_update_macros.svh */
// assertion helpers for the heat-bath update block
`ifndef THREE_SPIN_HEAT_BATH_UPDATE_MACROS_SVH
`define THREE_SPIN_HEAT_BATH_UPDATE_MACROS_SVH

// same-cycle implication
`define TSBU_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tsbu assertion failed");

// next-cycle implication
`define TSBU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tsbu assertion failed");

`endif

/* src/tsbu_pkg.sv */
`timescale 1ns / 1ps
package tsbu_pkg;

  localparam int IDW = 9;
  localparam int THR_W = 33;
  localparam int RND_W = 32;
  localparam int FIELD_OUT_W = 6;
  localparam int MAG_OUT_W = 11;

  localparam int DEF_NODES = 512;
  localparam int DEF_MAX_PAIRS = 16;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_UPDATE = 2'd2;
  localparam logic [1:0] OP_THRESH = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_SELF = 2'd2;

  typedef struct packed {
    logic [IDW-1:0] node;
    logic [IDW-1:0] partner_a;
    logic [IDW-1:0] partner_b;
  } ids_t;

endpackage

/* src/three_spin_heat_bath_update.sv */
`timescale 1ns / 1ps
// Heat-bath update engine for spins with three-body couplings.
// Requests: drive operation and its fields with start high; a request is
// taken at a rising edge where start is high and busy is low. Every request
// gives exactly one result, shown for one cycle with done high; the receiver
// cannot stall it, so it must sample at that edge.
// Operations: clear (spins up, lists emptied, thresholds kept), add a pair to
// a node list (status reports self pair or full list), heat-bath update of a
// node, and threshold word write.
// In an update, the pair loop reads one stored pair per cycle from the pair
// memory and both partner spins from two spin memory copies, pipelined.
// Clear runs a sweep that writes every node entry of the spin and count
// memories.
// Busy is high from acceptance until done rises; the next request may start
// at the edge that ends the done cycle.
// Reset (synchronous, rst high) runs the same sweep with busy high and gives
// no result; magnetization starts at NODES.
module three_spin_heat_bath_update #(
  parameter int NODES = tsbu_pkg::DEF_NODES,
  parameter int MAX_PAIRS = tsbu_pkg::DEF_MAX_PAIRS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        operation,
  input  logic [tsbu_pkg::IDW-1:0]          node,
  input  logic [tsbu_pkg::IDW-1:0]          partner_a,
  input  logic [tsbu_pkg::IDW-1:0]          partner_b,
  input  logic [tsbu_pkg::RND_W-1:0]        random_fraction,
  input  logic signed [5:0]                 field_index,
  input  logic [tsbu_pkg::THR_W-1:0]        threshold_word,
  output logic                              done,
  output logic [1:0]                        status,
  output logic                              spin_up,
  output logic signed [tsbu_pkg::FIELD_OUT_W-1:0] local_field,
  output logic signed [tsbu_pkg::MAG_OUT_W-1:0]   net_magnetization
);
  import tsbu_pkg::*;
  `include "three_spin_heat_bath_update_macros.svh"

  localparam int NODE_AW = $clog2(NODES);
  localparam int CNT_W = $clog2(MAX_PAIRS + 1);
  localparam int PAIR_W = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int PAIR_DEPTH = NODES * (1 << PAIR_W);
  localparam int PAIR_AW = NODE_AW + PAIR_W;
  localparam int TBL_DEPTH = 2 * MAX_PAIRS + 1;
  localparam int TBL_AW = $clog2(TBL_DEPTH);
  localparam int FIELD_W = $clog2(MAX_PAIRS + 1) + 1;
  localparam int MAG_W = $clog2(NODES + 1) + 1;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SWEEP    = 4'd1;
  localparam logic [3:0] S_WRAP1    = 4'd2;
  localparam logic [3:0] S_WRAP2    = 4'd3;
  localparam logic [3:0] S_THR_WR   = 4'd4;
  localparam logic [3:0] S_ADD_RD   = 4'd5;
  localparam logic [3:0] S_ADD_WR   = 4'd6;
  localparam logic [3:0] S_UPD_RD   = 4'd7;
  localparam logic [3:0] S_UPD_CNT  = 4'd8;
  localparam logic [3:0] S_UPD_PAIR = 4'd9;
  localparam logic [3:0] S_UPD_LOOK = 4'd10;
  localparam logic [3:0] S_UPD_WR   = 4'd11;

  logic [3:0] state;
  logic [NODE_AW-1:0] sweep_idx;
  logic sweep_reply;

  // captured request
  logic [1:0] cap_op;
  ids_t cap_ids;
  logic [RND_W-1:0] cap_rnd;
  logic signed [5:0] cap_fidx;
  logic [THR_W-1:0] cap_thr;
  ids_t ids;

  // update loop
  logic [CNT_W-1:0] pair_n;
  logic [CNT_W-1:0] pair_k;
  logic v1;
  logic v2;
  logic old_spin;
  logic signed [FIELD_W-1:0] field;
  logic signed [MAG_W-1:0] magnet;

  // memory ports
  logic count_we;
  logic [NODE_AW-1:0] node_waddr;
  logic [CNT_W-1:0] count_wdata;
  logic [CNT_W-1:0] count_rdata;
  logic spin_we;
  logic spin_wdata;
  logic [NODE_AW-1:0] spin_a_raddr;
  logic [NODE_AW-1:0] spin_b_raddr;
  logic spin_a_rdata;
  logic spin_b_rdata;
  logic pair_we;
  logic [PAIR_AW-1:0] pair_waddr;
  logic [PAIR_AW-1:0] pair_raddr;
  logic [2*IDW-1:0] pair_rdata;
  logic thr_we;
  logic [TBL_AW-1:0] thr_waddr;
  logic [TBL_AW-1:0] thr_raddr;
  logic [THR_W-1:0] thr_rdata;

  logic [NODE_AW-1:0] node_addr;
  logic sweeping;
  logic self_pair;
  logic list_full;
  logic issue;
  logic up;
  logic signed [31:0] fidx_ext;
  logic signed [31:0] fidx_sum;
  logic thr_in_range;
  logic signed [31:0] field_ext;
  logic signed [31:0] field_sum;
  logic signed [31:0] mag_ext;

  tsbu_wrap #(.NODES(NODES)) u_wrap (
    .clk     (clk),
    .raw     (cap_ids),
    .wrapped (ids)
  );

  assign node_addr = NODE_AW'(ids.node);
  assign sweeping = (state == S_SWEEP);
  assign self_pair = (ids.node == ids.partner_a) || (ids.node == ids.partner_b);
  assign list_full = (count_rdata >= CNT_W'(MAX_PAIRS));
  assign issue = (pair_k != pair_n);
  assign up = ({1'b0, cap_rnd} < thr_rdata);

  assign fidx_ext = 32'(cap_fidx);
  assign fidx_sum = fidx_ext + 32'(MAX_PAIRS);
  assign thr_in_range = (fidx_ext >= -MAX_PAIRS) && (fidx_ext <= MAX_PAIRS);
  assign field_ext = 32'(field);
  assign field_sum = field_ext + 32'(MAX_PAIRS);
  assign mag_ext = 32'(magnet);

  assign node_waddr = sweeping ? sweep_idx : node_addr;
  assign count_we = sweeping || ((state == S_ADD_WR) && !self_pair && !list_full);
  assign count_wdata = sweeping ? '0 : count_rdata + CNT_W'(1);
  assign spin_we = sweeping || (state == S_UPD_WR);
  assign spin_wdata = sweeping || up;
  assign spin_a_raddr = (state == S_UPD_RD) ? node_addr
                                            : NODE_AW'(pair_rdata[2*IDW-1:IDW]);
  assign spin_b_raddr = NODE_AW'(pair_rdata[IDW-1:0]);
  assign pair_we = (state == S_ADD_WR) && !self_pair && !list_full;
  assign pair_waddr = {node_addr, PAIR_W'(count_rdata)};
  assign pair_raddr = {node_addr, PAIR_W'(pair_k)};
  assign thr_we = (state == S_THR_WR) && thr_in_range;
  assign thr_waddr = fidx_sum[TBL_AW-1:0];
  assign thr_raddr = field_sum[TBL_AW-1:0];

  tsbu_ram #(.WIDTH(CNT_W), .DEPTH(NODES)) u_count_ram (
    .clk   (clk),
    .we    (count_we),
    .waddr (node_waddr),
    .wdata (count_wdata),
    .raddr (node_addr),
    .rdata (count_rdata)
  );

  tsbu_ram #(.WIDTH(1), .DEPTH(NODES)) u_spin_a_ram (
    .clk   (clk),
    .we    (spin_we),
    .waddr (node_waddr),
    .wdata (spin_wdata),
    .raddr (spin_a_raddr),
    .rdata (spin_a_rdata)
  );

  tsbu_ram #(.WIDTH(1), .DEPTH(NODES)) u_spin_b_ram (
    .clk   (clk),
    .we    (spin_we),
    .waddr (node_waddr),
    .wdata (spin_wdata),
    .raddr (spin_b_raddr),
    .rdata (spin_b_rdata)
  );

  tsbu_ram #(.WIDTH(2 * IDW), .DEPTH(PAIR_DEPTH)) u_pair_ram (
    .clk   (clk),
    .we    (pair_we),
    .waddr (pair_waddr),
    .wdata ({ids.partner_a, ids.partner_b}),
    .raddr (pair_raddr),
    .rdata (pair_rdata)
  );

  tsbu_ram #(.WIDTH(THR_W), .DEPTH(TBL_DEPTH)) u_thr_ram (
    .clk   (clk),
    .we    (thr_we),
    .waddr (thr_waddr),
    .wdata (cap_thr),
    .raddr (thr_raddr),
    .rdata (thr_rdata)
  );

  assign busy = (state != S_IDLE);
  assign net_magnetization = mag_ext[MAG_OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cap_op            <= operation;
      cap_ids.node      <= node;
      cap_ids.partner_a <= partner_a;
      cap_ids.partner_b <= partner_b;
      cap_rnd           <= random_fraction;
      cap_fidx          <= field_index;
      cap_thr           <= threshold_word;
    end
    if (state == S_UPD_CNT) begin
      pair_n   <= count_rdata;
      old_spin <= spin_a_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_SWEEP;
      sweep_idx   <= '0;
      sweep_reply <= 1'b0;
      done        <= 1'b0;
      magnet      <= MAG_W'(NODES);
      pair_k      <= '0;
      v1          <= 1'b0;
      v2          <= 1'b0;
      field       <= '0;
      status      <= ST_OK;
      spin_up     <= 1'b0;
      local_field <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_WRAP1;
          end
        end
        S_SWEEP: begin
          sweep_idx <= sweep_idx + NODE_AW'(1);
          if (sweep_idx == NODE_AW'(NODES - 1)) begin
            state       <= S_IDLE;
            sweep_idx   <= '0;
            magnet      <= MAG_W'(NODES);
            done        <= sweep_reply;
            sweep_reply <= 1'b0;
            status      <= ST_OK;
            spin_up     <= 1'b0;
            local_field <= '0;
          end
        end
        S_WRAP1: begin
          state <= S_WRAP2;
        end
        S_WRAP2: begin
          case (cap_op)
            OP_CLEAR: begin
              state       <= S_SWEEP;
              sweep_reply <= 1'b1;
            end
            OP_ADD:    state <= S_ADD_RD;
            OP_UPDATE: state <= S_UPD_RD;
            default:   state <= S_THR_WR;
          endcase
        end
        S_THR_WR: begin
          state       <= S_IDLE;
          done        <= 1'b1;
          status      <= ST_OK;
          spin_up     <= 1'b0;
          local_field <= '0;
        end
        S_ADD_RD: begin
          state <= S_ADD_WR;
        end
        S_ADD_WR: begin
          state       <= S_IDLE;
          done        <= 1'b1;
          spin_up     <= 1'b0;
          local_field <= '0;
          if (self_pair) begin
            status <= ST_SELF;
          end else if (list_full) begin
            status <= ST_FULL;
          end else begin
            status <= ST_OK;
          end
        end
        S_UPD_RD: begin
          state <= S_UPD_CNT;
        end
        S_UPD_CNT: begin
          state  <= S_UPD_PAIR;
          pair_k <= '0;
          v1     <= 1'b0;
          v2     <= 1'b0;
          field  <= '0;
        end
        S_UPD_PAIR: begin
          if (issue) begin
            pair_k <= pair_k + CNT_W'(1);
          end
          v1 <= issue;
          v2 <= v1;
          if (v2) begin
            field <= (spin_a_rdata == spin_b_rdata) ? field + FIELD_W'(1)
                                                    : field - FIELD_W'(1);
          end
          if (!issue && !v1 && !v2) begin
            state <= S_UPD_LOOK;
          end
        end
        S_UPD_LOOK: begin
          state <= S_UPD_WR;
        end
        S_UPD_WR: begin
          state       <= S_IDLE;
          done        <= 1'b1;
          status      <= ST_OK;
          spin_up     <= up;
          local_field <= field_ext[FIELD_OUT_W-1:0];
          if (up && !old_spin) begin
            magnet <= magnet + MAG_W'(2);
          end else if (!up && old_spin) begin
            magnet <= magnet - MAG_W'(2);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `TSBU_ASSERT_NEXT(a_done_single, clk, rst, done, !done)
  `TSBU_ASSERT_SAME(a_done_idle, clk, rst, done, state == S_IDLE)
  `TSBU_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy && !done)
  `TSBU_ASSERT_SAME(a_pair_bound, clk, rst, state == S_UPD_PAIR, pair_k <= pair_n)
  `TSBU_ASSERT_SAME(a_status_code, clk, rst, done, status != 2'd3)
  `TSBU_ASSERT_SAME(a_add_no_spin, clk, rst, pair_we, !spin_we && !thr_we)

endmodule

/* src/tsbu_ram.sv */
`timescale 1ns / 1ps
module tsbu_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/tsbu_wrap.sv */
`timescale 1ns / 1ps
module tsbu_wrap #(
  parameter int NODES = tsbu_pkg::DEF_NODES
) (
  input  logic          clk,
  input  tsbu_pkg::ids_t raw,
  output tsbu_pkg::ids_t wrapped
);
  import tsbu_pkg::*;

  // reciprocal estimate, quotient may come out one low
  localparam int SHIFT = 18;
  localparam int RECIP = (1 << SHIFT) / NODES;

  logic [IDW-1:0] val   [3];
  logic [IDW-1:0] quot  [3];
  logic [IDW-1:0] val_q [3];
  logic [IDW-1:0] rem   [3];

  assign val[0] = raw.node;
  assign val[1] = raw.partner_a;
  assign val[2] = raw.partner_b;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      logic [31:0] prod;
      prod = 32'(val[i]) * 32'(RECIP);
      quot[i]  <= prod[SHIFT+IDW-1:SHIFT];
      val_q[i] <= val[i];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [31:0] r;
      r = 32'(val_q[i]) - 32'(quot[i]) * 32'(NODES);
      if (r >= 32'(NODES)) begin
        r = r - 32'(NODES);
      end
      rem[i] = r[IDW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    wrapped.node      <= rem[0];
    wrapped.partner_a <= rem[1];
    wrapped.partner_b <= rem[2];
  end

endmodule

/* dv/three_spin_heat_bath_update_tb.sv */
`timescale 1ns / 1ps
module testbench;
  import tsbu_pkg::*;

  localparam int NODE_COUNT = DEF_NODES;
  localparam int PAIR_LIMIT = DEF_MAX_PAIRS;
  localparam int TABLE_SIZE = 2 * PAIR_LIMIT + 1;
  localparam int RANDOM_ITEMS = 1050;
  localparam int REPORT_LIMIT = 10;
  localparam int CYCLE_LIMIT = 3_000_000;

  typedef struct packed {
    logic [1:0]             status;
    logic                   spin;
    logic [FIELD_OUT_W-1:0] field;
    logic [MAG_OUT_W-1:0]   magnet;
  } bath_result_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic [1:0]                    operation = OP_CLEAR;
  logic [IDW-1:0]                node = '0;
  logic [IDW-1:0]                partner_a = '0;
  logic [IDW-1:0]                partner_b = '0;
  logic [RND_W-1:0]              random_fraction = '0;
  logic signed [5:0]             field_index = '0;
  logic [THR_W-1:0]              threshold_word = '0;
  logic                          busy;
  logic                          done;
  logic [1:0]                    status;
  logic                          spin_up;
  logic signed [FIELD_OUT_W-1:0] local_field;
  logic signed [MAG_OUT_W-1:0]   net_magnetization;

  bit             spin_model [NODE_COUNT];
  logic [IDW-1:0] pair_a_model [NODE_COUNT][PAIR_LIMIT];
  logic [IDW-1:0] pair_b_model [NODE_COUNT][PAIR_LIMIT];
  int             pair_cnt_model [NODE_COUNT];
  logic [THR_W-1:0] thr_model [TABLE_SIZE];
  int             magnet_model;

  bath_result_t awaited_outcomes [$];
  int fail_count = 0;
  int quiet_run = 0;
  int cycle_count;

  three_spin_heat_bath_update u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .operation(operation),
    .node(node),
    .partner_a(partner_a),
    .partner_b(partner_b),
    .random_fraction(random_fraction),
    .field_index(field_index),
    .threshold_word(threshold_word),
    .done(done),
    .status(status),
    .spin_up(spin_up),
    .local_field(local_field),
    .net_magnetization(net_magnetization)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int next_gap();
    int r;
    if (quiet_run > 0) begin
      quiet_run--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      quiet_run = $urandom_range(10, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [IDW-1:0] pick_node(input int pool_top);
    if ($urandom_range(0, 9) < 7) return IDW'($urandom_range(0, pool_top));
    return IDW'($urandom());
  endfunction

  task automatic predict_heat_bath(input logic [1:0] op, input logic [IDW-1:0] nd,
                                   input logic [IDW-1:0] pa, input logic [IDW-1:0] pb,
                                   input logic [RND_W-1:0] rnd,
                                   input logic signed [5:0] fidx,
                                   input logic [THR_W-1:0] thr,
                                   output bath_result_t res);
    int fld;
    int fi;
    int slot;
    logic up;
    res = '0;
    fld = 0;
    fi = fidx;
    case (op)
      OP_CLEAR: begin
        foreach (spin_model[i]) spin_model[i] = 1'b1;
        foreach (pair_cnt_model[i]) pair_cnt_model[i] = 0;
        magnet_model = NODE_COUNT;
      end
      OP_ADD: begin
        if (nd == pa || nd == pb) begin
          res.status = ST_SELF;
        end else if (pair_cnt_model[nd] >= PAIR_LIMIT) begin
          res.status = ST_FULL;
        end else begin
          slot = pair_cnt_model[nd];
          pair_a_model[nd][slot] = pa;
          pair_b_model[nd][slot] = pb;
          pair_cnt_model[nd]++;
        end
      end
      OP_UPDATE: begin
        for (int k = 0; k < pair_cnt_model[nd]; k++)
          fld += (spin_model[pair_a_model[nd][k]] == spin_model[pair_b_model[nd][k]]) ? 1 : -1;
        up = {1'b0, rnd} < thr_model[fld + PAIR_LIMIT];
        if (up && !spin_model[nd]) magnet_model += 2;
        else if (!up && spin_model[nd]) magnet_model -= 2;
        spin_model[nd] = up;
        res.spin = up;
      end
      default: begin
        if (fi >= -PAIR_LIMIT && fi <= PAIR_LIMIT) thr_model[fi + PAIR_LIMIT] = thr;
      end
    endcase
    res.field = fld[FIELD_OUT_W-1:0];
    res.magnet = magnet_model[MAG_OUT_W-1:0];
  endtask

  task automatic issue_request(input logic [1:0] op, input logic [IDW-1:0] nd,
                               input logic [IDW-1:0] pa, input logic [IDW-1:0] pb,
                               input logic [RND_W-1:0] rnd,
                               input logic signed [5:0] fidx,
                               input logic [THR_W-1:0] thr);
    bath_result_t res;
    int gap;
    start <= 1'b1;
    operation <= op;
    node <= nd;
    partner_a <= pa;
    partner_b <= pb;
    random_fraction <= rnd;
    field_index <= fidx;
    threshold_word <= thr;
    do @(posedge clk); while (busy);
    predict_heat_bath(op, nd, pa, pb, rnd, fidx, thr, res);
    awaited_outcomes.push_back(res);
    gap = next_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic test_threshold_table();
    logic [THR_W-1:0] word;
    for (int f = -PAIR_LIMIT; f <= PAIR_LIMIT; f++) begin
      word = {1'b0, $urandom()};
      if (f == -PAIR_LIMIT) word = '0;
      if (f == PAIR_LIMIT - 1) word = '1;
      if (f == PAIR_LIMIT) word = 33'h1_0000_0000;
      issue_request(OP_THRESH, '0, '0, '0, '0, 6'(f), word);
    end
    // indexes beyond the table are dropped
    issue_request(OP_THRESH, '0, '0, '0, '0, 6'b100000, '1);
    issue_request(OP_THRESH, '0, '0, '0, '0, 6'b011111, '0);
    issue_request(OP_THRESH, '0, '0, '0, '0, 6'(-PAIR_LIMIT - 1), '1);
    issue_request(OP_THRESH, '0, '0, '0, '0, 6'(PAIR_LIMIT + 1), '0);
  endtask

  task automatic test_add_status();
    issue_request(OP_CLEAR, '1, '1, '1, '1, '1, '1);
    issue_request(OP_ADD, 9'd5, 9'd5, 9'd9, '0, '0, '0);
    issue_request(OP_ADD, 9'd5, 9'd9, 9'd5, '0, '0, '0);
    issue_request(OP_ADD, 9'd5, 9'd5, 9'd5, '0, '0, '0);
    // equal partners always multiply to plus one
    issue_request(OP_ADD, 9'd5, 9'd7, 9'd7, '0, '0, '0);
    issue_request(OP_ADD, 9'd5, 9'd511, 9'd0, '0, '0, '0);
    for (int k = 2; k < PAIR_LIMIT; k++)
      issue_request(OP_ADD, 9'd5, IDW'(10 + k), IDW'(30 + k), '0, '0, '0);
    issue_request(OP_ADD, 9'd5, 9'd40, 9'd41, '0, '0, '0);
    // self pair wins over full list
    issue_request(OP_ADD, 9'd5, 9'd41, 9'd5, '0, '0, '0);
    issue_request(OP_ADD, 9'd511, 9'd0, 9'd510, '0, '0, '0);
  endtask

  task automatic test_update_extremes();
    issue_request(OP_UPDATE, 9'd5, '0, '0, '1, '0, '0);
    issue_request(OP_UPDATE, 9'd9, '0, '0, '0, '0, '0);
    issue_request(OP_UPDATE, 9'd9, '0, '0, '1, '0, '0);
    issue_request(OP_UPDATE, 9'd511, '0, '0, $urandom(), '0, '0);
    issue_request(OP_UPDATE, 9'd7, '0, '0, '1, '0, '0);
    issue_request(OP_UPDATE, 9'd5, '0, '0, $urandom(), '0, '0);
    issue_request(OP_CLEAR, '0, '0, '0, '0, '0, '0);
    issue_request(OP_UPDATE, 9'd5, '0, '0, $urandom(), '0, '0);
  endtask

  task automatic test_random_traffic(input int count);
    logic [1:0]        op;
    logic [IDW-1:0]    nd;
    logic [IDW-1:0]    pa;
    logic [IDW-1:0]    pb;
    logic [RND_W-1:0]  rnd;
    logic signed [5:0] fidx;
    logic [THR_W-1:0]  thr;
    int r;
    repeat (count) begin
      r = $urandom_range(0, 999);
      nd = pick_node(23);
      pa = pick_node(23);
      pb = pick_node(23);
      rnd = $urandom();
      fidx = 6'($urandom());
      thr = {1'($urandom()), $urandom()};
      if (r < 6) begin
        op = OP_CLEAR;
      end else if (r < 70) begin
        op = OP_THRESH;
      end else if (r < 520) begin
        op = OP_ADD;
        nd = pick_node(3);
        case ($urandom_range(0, 11))
          0: pa = nd;
          1: pb = nd;
          2: pb = pa;
          default: ;
        endcase
      end else begin
        op = OP_UPDATE;
      end
      issue_request(op, nd, pa, pb, rnd, fidx, thr);
    end
  endtask

  always @(posedge clk) begin : check_outcomes
    bath_result_t got;
    bath_result_t want;
    got = {status, spin_up, local_field, net_magnetization};
    if (!rst && done) begin
      if (awaited_outcomes.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("unexpected result: status=%0d spin=%0d field=%0d mag=%0d",
                   got.status, got.spin, $signed(got.field), $signed(got.magnet));
      end else begin
        want = awaited_outcomes.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("mismatch: expected status=%0d spin=%0d field=%0d mag=%0d, %s%0d %s%0d %s%0d %s%0d",
                     want.status, want.spin, $signed(want.field), $signed(want.magnet),
                     "got status=", got.status, "spin=", got.spin,
                     "field=", $signed(got.field), "mag=", $signed(got.magnet));
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("three_spin_heat_bath_update verification failed");
    $finish;
  end

  initial begin
    foreach (spin_model[i]) spin_model[i] = 1'b1;
    foreach (pair_cnt_model[i]) pair_cnt_model[i] = 0;
    magnet_model = NODE_COUNT;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_threshold_table();
    test_add_status();
    test_update_extremes();
    test_random_traffic(RANDOM_ITEMS);
    start <= 1'b0;
    while (awaited_outcomes.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && awaited_outcomes.size() == 0) begin
      $display("three_spin_heat_bath_update verification clean");
    end else begin
      $display("three_spin_heat_bath_update verification failed");
    end
    $finish;
  end

endmodule
